// ===== design/gwm_pkg.sv =====
// Package for the glob wildcard matcher.
// Holds pattern geometry, special pattern bytes, register indexes and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps

package gwm_pkg;

    // Pattern storage: four 64-bit registers of eight bytes each
    localparam int PAT_WORDS       = 4;
    localparam int PAT_WORD_W      = 64;
    localparam int BYTE_W          = 8;
    localparam int BYTES_PER_WORD  = PAT_WORD_W / BYTE_W;
    localparam int PAT_BYTES       = PAT_WORDS * BYTES_PER_WORD;
    localparam int LEN_W           = 6;
    localparam int PATTERN_MAX_DEF = 32;

    // Pattern bytes with a special meaning
    localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;
    localparam logic [BYTE_W-1:0] ANY_BYTE  = 8'h3F;

    // Register indexes on the config port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD0 = 3'd1;

    // Control shared by every cell of the chain
    typedef struct packed {
        logic step;     // a character word is taken this cycle
        logic restart;  // that word ends the string (last or empty)
    } t_cell_ctl;

endpackage

// ===== design/gwm_cell.sv =====
// One cell of the live-position chain: holds one live bit of the NFA.
// Computes closure, advance and closure again for its position from its neighbor's carries.
// Depends on gwm_pkg.
`timescale 1ns / 1ps

module gwm_cell
    import gwm_pkg::*;
#(
    parameter logic START_BIT = 1'b0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [BYTE_W-1:0] i_pat_byte,
    input  logic [BYTE_W-1:0] i_char,
    input  logic              i_active,   // position below pattern length
    input  logic              i_inside,   // position not beyond pattern length
    input  logic              i_pcarry,   // closure carry, live set before the character
    input  logic              i_shift,    // advance from the lower neighbor
    input  logic              i_carry,    // closure carry, current string
    input  logic              i_scarry,   // closure carry, start state
    output logic              o_pcarry,
    output logic              o_shift,
    output logic              o_carry,
    output logic              o_scarry,
    output logic              o_closed,
    output logic              o_sclosed
);

    logic r_live;
    logic n_live;
    logic is_star;
    logic hit;
    logic pre;
    logic adv;

    // Classify the pattern byte at this position
    assign is_star = i_active && (i_pat_byte == STAR_BYTE);
    assign hit     = i_active && (i_pat_byte != STAR_BYTE)
                     && ((i_pat_byte == ANY_BYTE) || (i_pat_byte == i_char));

    // Stored live set closed against the current pattern
    assign pre      = (r_live || i_pcarry) && i_inside;
    assign o_pcarry = pre && is_star;

    // Advance: a star keeps its position, a hit moves on to the neighbor
    assign o_shift = pre && hit;
    assign adv     = o_pcarry || i_shift;

    // Star closure rippling up the chain
    assign o_closed  = (adv || i_carry) && i_inside;
    assign o_carry   = o_closed && is_star;
    assign o_sclosed = (START_BIT || i_scarry) && i_inside;
    assign o_scarry  = o_sclosed && is_star;

    // Next live bit
    always_comb begin
        priority if (i_ctl.restart) begin
            n_live = START_BIT;
        end else if (i_ctl.step) begin
            n_live = o_closed;
        end else begin
            n_live = r_live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= START_BIT;
        end else begin
            r_live <= n_live;
        end
    end

endmodule

// ===== design/glob_wildcard_matcher.sv =====
// Top level of the glob wildcard matcher: config registers, cell chain, output register.
// Depends on gwm_pkg and gwm_cell.
`timescale 1ns / 1ps

// Matches a stream of characters against a glob pattern of up to 32 bytes
// ('*' any run, '?' any one character, other bytes literal; a zero byte is an
// ordinary character). One character word is taken per cycle, back to back;
// the result of a string leaves through the output register in the cycle after
// its last word (or its empty-string word) is taken, and a waiting result
// holds off the input only while the sink is not ready. Each word is handled by
// the chain of PATTERN_MAX+1 cells: combinationally, the star closure of
// the stored live positions ripples up the chain, the character advances each
// live position, and the closure ripples up the chain again. Config writes are
// taken at once and never stall the input; the stored live positions are kept
// and closed against the current pattern when the next word arrives, so a
// string in progress carries on with the new pattern.
module glob_wildcard_matcher
    import gwm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [PAT_WORD_W-1:0] i_cfg_data,
    // Character stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] char_byte
    input  logic                  s_axis_tlast,   // last_char
    input  logic                  s_axis_tuser,   // empty_string
    // Match results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata    // [0] matched, [7:1] zero
);

    localparam int NW = $clog2(PATTERN_MAX + 1);

    logic [LEN_W-1:0]      r_len;
    logic [PAT_WORD_W-1:0] r_pat [PAT_WORDS];
    logic                  r_out_valid;
    logic                  r_out_matched;
    logic                  n_out_valid;
    logic                  n_out_matched;

    logic [NW-1:0]         eff_len;
    logic                  in_accept;
    logic                  cfg_accept;
    t_cell_ctl             ctl;

    logic [PATTERN_MAX+1:0] pcarry;
    logic [PATTERN_MAX+1:0] shift;
    logic [PATTERN_MAX+1:0] carry;
    logic [PATTERN_MAX+1:0] scarry;
    logic [PATTERN_MAX:0]   closed;
    logic [PATTERN_MAX:0]   sclosed;

    // Handshakes
    assign o_cfg_ready   = 1'b1;
    assign cfg_accept    = i_cfg_valid && o_cfg_ready;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            for (int w = 0; w < PAT_WORDS; w++) begin
                r_pat[w] <= '0;
            end
        end else if (cfg_accept) begin
            if (i_cfg_index == CFG_LEN) begin
                r_len <= i_cfg_data[LEN_W-1:0];
            end
            for (int w = 0; w < PAT_WORDS; w++) begin
                if (i_cfg_index == CFG_WORD0 + CFG_IDX_W'(w)) begin
                    r_pat[w] <= i_cfg_data;
                end
            end
        end
    end

    // Pattern length saturated at PATTERN_MAX
    always_comb begin
        if ({1'b0, r_len} > (LEN_W + 1)'(PATTERN_MAX)) begin
            eff_len = NW'(PATTERN_MAX);
        end else begin
            eff_len = NW'(r_len);
        end
    end

    // Cell control
    assign ctl.step    = in_accept;
    assign ctl.restart = in_accept && (s_axis_tlast || s_axis_tuser);

    // Chain ends
    assign pcarry[0] = 1'b0;
    assign shift[0]  = 1'b0;
    assign carry[0]  = 1'b0;
    assign scarry[0] = 1'b0;

    // Row of cells, one per pattern position plus the accepting position
    for (genvar k = 0; k <= PATTERN_MAX; k++) begin : g_cell
        localparam logic [NW-1:0] POS = NW'(k);
        logic [BYTE_W-1:0] pat_byte;

        if (k < PAT_BYTES) begin : g_byte
            assign pat_byte = r_pat[k / BYTES_PER_WORD][(k % BYTES_PER_WORD) * BYTE_W +: BYTE_W];
        end else begin : g_zero
            assign pat_byte = '0;
        end

        gwm_cell #(
            .START_BIT (k == 0)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_pat_byte (pat_byte),
            .i_char     (s_axis_tdata),
            .i_active   (POS < eff_len),
            .i_inside   (POS <= eff_len),
            .i_pcarry   (pcarry[k]),
            .i_shift    (shift[k]),
            .i_carry    (carry[k]),
            .i_scarry   (scarry[k]),
            .o_pcarry   (pcarry[k+1]),
            .o_shift    (shift[k+1]),
            .o_carry    (carry[k+1]),
            .o_scarry   (scarry[k+1]),
            .o_closed   (closed[k]),
            .o_sclosed  (sclosed[k])
        );
    end

    // Output register
    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_matched = r_out_matched;
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (ctl.restart) begin
            n_out_valid   = 1'b1;
            n_out_matched = s_axis_tuser ? sclosed[eff_len] : closed[eff_len];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_matched <= n_out_matched;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_matched};

    // Checks
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input not ready with the output register empty");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while stalled");

    a_restart_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.restart |=> r_out_valid)
        else $error("string end produced no result");

    a_restart_start_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.restart |=> g_cell[0].u_cell.r_live)
        else $error("start position not live after string end");

endmodule

// ===== tb/tb_glob_wildcard_matcher.sv =====
// Self-checking testbench for glob_wildcard_matcher: directed and random strings
// against configured glob patterns, checked by a scoreboard class holding a predictor.
// Depends on gwm_pkg and the glob_wildcard_matcher RTL.
`timescale 1ns / 1ps

module tb_glob_wildcard_matcher;
    import gwm_pkg::*;

    localparam int NPOS          = PATTERN_MAX_DEF + 1;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_WORDS  = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(CFG_WORD0 + PAT_WORDS);
    localparam logic [7:0] CHAR_A = 8'h61;  // 'a', base of the small test alphabet

    // Predicts the matched flag of each string and checks the result words
    class glob_match_scoreboard;
        bit [LEN_W-1:0]  len_reg;
        bit [BYTE_W-1:0] pat [PAT_BYTES];
        bit [NPOS-1:0]   live;
        bit              expected_match_q[$];
        int              errors;

        function new();
            len_reg = '0;
            foreach (pat[k]) pat[k] = '0;
            live   = NPOS'(1);
            errors = 0;
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [PAT_WORD_W-1:0] data);
            int base;
            base = (int'(idx) - int'(CFG_WORD0)) * BYTES_PER_WORD;
            if (idx == CFG_LEN) begin
                len_reg = data[LEN_W-1:0];
            end else if (idx >= CFG_WORD0 && int'(idx) < int'(CFG_WORD0) + PAT_WORDS) begin
                for (int b = 0; b < BYTES_PER_WORD; b++)
                    pat[base + b] = data[b*BYTE_W +: BYTE_W];
            end
        endfunction

        // length register saturates at the pattern storage size
        function int pat_len();
            return (len_reg > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(len_reg);
        endfunction

        function bit [NPOS-1:0] close_stars(bit [NPOS-1:0] v, int n);
            for (int i = 0; i < n; i++)
                if (v[i] && pat[i] == STAR_BYTE) v[i+1] = 1'b1;
            for (int i = n + 1; i < NPOS; i++) v[i] = 1'b0;
            return v;
        endfunction

        function bit [NPOS-1:0] take_char(bit [NPOS-1:0] v, bit [7:0] c, int n);
            bit [NPOS-1:0] nv;
            nv = '0;
            for (int i = 0; i < n; i++) begin
                if (v[i]) begin
                    if (pat[i] == STAR_BYTE)
                        nv[i] = 1'b1;
                    else if (pat[i] == ANY_BYTE || pat[i] == c)
                        nv[i+1] = 1'b1;
                end
            end
            return nv;
        endfunction

        function void note_char_word(bit [7:0] c, bit last, bit empty);
            int n;
            bit [NPOS-1:0] v;
            n = pat_len();
            if (empty) begin
                v = close_stars(NPOS'(1), n);
                expected_match_q.push_back(v[n]);
                live = NPOS'(1);
            end else begin
                v = close_stars(take_char(close_stars(live, n), c, n), n);
                if (last) begin
                    expected_match_q.push_back(v[n]);
                    live = NPOS'(1);
                end else begin
                    live = v;
                end
            end
        endfunction

        function void check_match_word(logic [7:0] tdata);
            bit want;
            if (expected_match_q.size() == 0) begin
                $display("%0t: match word with none expected: expected none, actual %h",
                         $time, tdata);
                errors++;
                return;
            end
            want = expected_match_q.pop_front();
            if (tdata[0] !== want) begin
                $display("%0t: matched mismatch: expected %0d, actual %b", $time, want, tdata[0]);
                errors++;
            end
            if (tdata[7:1] !== 7'd0) begin
                $display("%0t: pad bits mismatch: expected 00, actual %b", $time, tdata[7:1]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_match_q.size();
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [PAT_WORD_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;   // [7:0] char_byte
    logic                  s_axis_tlast  = 1'b0; // last_char
    logic                  s_axis_tuser  = 1'b0; // empty_string
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;         // [0] matched, [7:1] zero

    glob_match_scoreboard board;
    bit   full_rate = 1'b0;  // no idling on either side
    bit   hold_req  = 1'b0;  // ask the sink for one long hold-off
    int   words_sent = 0;

    // pattern image loaded into the block, and the string being built
    logic [7:0]       pat_img [PAT_BYTES];
    logic [LEN_W-1:0] len_img;
    logic [7:0]       str_buf [$];

    glob_wildcard_matcher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int send_gap();
        int r;
        r = $urandom_range(0, 99);
        if (full_rate) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sink_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 6);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] alpha_char();
        return CHAR_A + 8'($urandom_range(0, 2));
    endfunction

    function automatic logic [7:0] glob_symbol();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9)  return alpha_char();
        if (r < 13) return ANY_BYTE;
        if (r < 18) return STAR_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int img_len();
        return (len_img > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(len_img);
    endfunction

    // one character word; noted once the handshake completes
    task automatic send_char(input logic [7:0] c, input logic last, input logic empty,
                             input int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        s_axis_tuser  <= empty;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_char_word(c, last, empty);
        words_sent++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sender stops until every expected result is back and the block has settled
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // leaves i_cfg_valid high; the caller drops it after the last register
    task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx,
                            input logic [PAT_WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
    endtask

    task automatic load_pattern();
        logic [PAT_WORD_W-1:0] packed_word;
        quiesce();
        cfg_word(CFG_LEN, PAT_WORD_W'(len_img));
        for (int w = 0; w < PAT_WORDS; w++) begin
            for (int b = 0; b < BYTES_PER_WORD; b++)
                packed_word[b*BYTE_W +: BYTE_W] = pat_img[w*BYTES_PER_WORD + b];
            cfg_word(CFG_IDX_W'(CFG_WORD0 + w), packed_word);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic fill_pattern(input logic [7:0] b, input logic [LEN_W-1:0] len);
        foreach (pat_img[k]) pat_img[k] = b;
        len_img = len;
    endtask

    // mostly short glob patterns over a small alphabet; some long, some raw noise
    task automatic random_pattern();
        int mode;
        int plen;
        mode = $urandom_range(0, 9);
        foreach (pat_img[k]) pat_img[k] = 8'($urandom_range(0, 255));
        if (mode == 0) begin
            len_img = LEN_W'($urandom_range(0, 63));
        end else begin
            plen = (mode == 1) ? $urandom_range(9, 32) : $urandom_range(0, 8);
            for (int k = 0; k < plen; k++) pat_img[k] = glob_symbol();
            len_img = (plen == PATTERN_MAX_DEF && $urandom_range(0, 1) == 1) ?
                      LEN_W'($urandom_range(32, 63)) : LEN_W'(plen);
        end
    endtask

    // strings mostly derived from the pattern, some mutated, the rest random
    task automatic build_string();
        int kind;
        int pos;
        logic [7:0] b;
        str_buf.delete();
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            for (int k = 0; k < img_len(); k++) begin
                b = pat_img[k];
                if (b == STAR_BYTE)
                    repeat ($urandom_range(0, 3)) str_buf.push_back(alpha_char());
                else if (b == ANY_BYTE)
                    str_buf.push_back(($urandom_range(0, 3) == 0) ?
                                      8'($urandom_range(0, 255)) : alpha_char());
                else
                    str_buf.push_back(b);
            end
            if (kind >= 5) begin
                case ($urandom_range(0, 2))
                    0: begin
                        if (str_buf.size() > 0) begin
                            pos = $urandom_range(0, str_buf.size() - 1);
                            str_buf[pos] = alpha_char();
                        end
                    end
                    1: begin
                        if (str_buf.size() > 0) void'(str_buf.pop_back());
                    end
                    default: str_buf.push_back(alpha_char());
                endcase
            end
        end else if (kind < 9) begin
            repeat ($urandom_range(0, 8)) str_buf.push_back(alpha_char());
        end else begin
            repeat ($urandom_range(0, 12)) str_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // a partial string ends with no last flag, so the next pattern takes over mid string
    task automatic send_string(input bit partial);
        int stop;
        if (str_buf.size() == 0) begin
            send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, send_gap());
        end else begin
            stop = partial ? $urandom_range(1, str_buf.size()) : str_buf.size();
            for (int k = 0; k < stop; k++) begin
                // an empty-string word inside a string restarts the matcher
                if (!partial && $urandom_range(0, 49) == 0)
                    send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
                              send_gap());
                send_char(str_buf[k], !partial && k == str_buf.size() - 1, 1'b0, send_gap());
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_match_word(m_axis_tdata);
    end

    // result sink: random back-pressure, one long hold-off on request
    initial begin
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (full_rate) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (sink_stall()) @(posedge i_clk);
            end
        end
    end

    // stimulus
    initial begin
        int rand_start;
        int phase;
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // after reset the pattern is empty: only the empty string matches
        send_char(8'hFF, 1'b1, 1'b1, 0);
        send_char(8'h00, 1'b1, 1'b0, 1);

        // a write to an unused index changes nothing
        quiesce();
        cfg_word(CFG_UNUSED, '1);
        i_cfg_valid <= 1'b0;
        send_char(8'h00, 1'b1, 1'b1, 0);

        // 31 stars then 'z', length register above the storage size
        fill_pattern(STAR_BYTE, 6'd63);
        pat_img[PAT_BYTES-1] = 8'h7A;
        load_pattern();
        send_char(8'h7A, 1'b1, 1'b0, 0);
        send_char(8'h7B, 1'b1, 1'b0, 2);
        send_char(8'h00, 1'b0, 1'b1, 0);

        // all-ones bytes as literals
        fill_pattern(8'hFF, 6'd2);
        load_pattern();
        send_char(8'hFF, 1'b0, 1'b0, 0);
        send_char(8'hFF, 1'b1, 1'b0, 0);
        send_char(8'hFF, 1'b1, 1'b0, 0);

        // zero byte is an ordinary character
        fill_pattern(8'h00, 6'd1);
        load_pattern();
        send_char(8'h00, 1'b1, 1'b0, 0);
        send_char(8'h00, 1'b1, 1'b1, 0);

        // "a?c*": literal, any-one, trailing star
        fill_pattern(8'h00, 6'd4);
        pat_img[0] = CHAR_A;
        pat_img[1] = ANY_BYTE;
        pat_img[2] = CHAR_A + 8'd2;
        pat_img[3] = STAR_BYTE;
        load_pattern();
        send_char(CHAR_A, 1'b0, 1'b0, 0);
        send_char(CHAR_A + 8'd1, 1'b0, 1'b0, 0);
        send_char(CHAR_A + 8'd2, 1'b1, 1'b0, 0);
        send_char(CHAR_A, 1'b0, 1'b0, 1);
        send_char(CHAR_A + 8'd1, 1'b1, 1'b0, 0);
        send_char(CHAR_A, 1'b0, 1'b0, 0);
        send_char(8'h00, 1'b0, 1'b0, 0);
        send_char(CHAR_A + 8'd2, 1'b1, 1'b0, 3);
        send_char(CHAR_A, 1'b0, 1'b0, 0);
        send_char(8'h78, 1'b0, 1'b0, 0);
        send_char(CHAR_A + 8'd2, 1'b0, 1'b0, 0);
        send_char(CHAR_A + 8'd3, 1'b1, 1'b0, 0);

        // pattern swapped in mid string: "a" taken, then "ab" finishes on 'b'
        send_char(CHAR_A, 1'b0, 1'b0, 0);
        pat_img[1] = CHAR_A + 8'd1;
        len_img    = 6'd2;
        load_pattern();
        send_char(CHAR_A + 8'd1, 1'b1, 1'b0, 0);

        // random phases, each with its own pattern
        rand_start = words_sent;
        phase = 0;
        while (words_sent - rand_start < RANDOM_WORDS) begin
            random_pattern();
            load_pattern();
            full_rate = ($urandom_range(0, 4) == 0);
            if (phase == 3 || phase == 25) begin
                full_rate = 1'b1;
                hold_req  = 1'b1;
            end
            repeat ($urandom_range(4, 30)) begin
                build_string();
                send_string(1'b0);
            end
            if ($urandom_range(0, 3) == 0) begin
                build_string();
                send_string(1'b1);
            end
            phase++;
        end

        quiesce();
        repeat (16) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("tb_glob_wildcard_matcher passed");
        end else begin
            $display("tb_glob_wildcard_matcher failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #50_000_000;
        $display("tb_glob_wildcard_matcher failed");
        $finish;
    end

endmodule
